[rtl/lcc_pkg.sv]
package lcc_pkg;

  localparam int LEXEME_MAX_DEF = 63;
  localparam int HEAD_DEPTH     = 8;
  localparam int HEAD_IDX_W     = $clog2(HEAD_DEPTH);
  localparam int SHORT_LEN_W    = $clog2(HEAD_DEPTH + 2);
  localparam int OUT_LEN_W      = 6;
  localparam int KEYWORD_COUNT  = 24;

  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] APOSTROPHE = 8'd39;

  typedef enum logic [2:0] {
    CAT_SEP     = 3'd0,
    CAT_PAR     = 3'd1,
    CAT_OP      = 3'd2,
    CAT_NUM     = 3'd3,
    CAT_KW      = 3'd4,
    CAT_ID      = 3'd5,
    CAT_UNKNOWN = 3'd6
  } category_t;

  typedef enum logic [1:0] {
    NUM_START = 2'd0,
    NUM_INT   = 2'd1,
    NUM_DOT   = 2'd2,
    NUM_FRAC  = 2'd3
  } num_phase_t;

  // Snapshot of the open lexeme handed to the classifier. short_len holds the
  // length while it fits the head buffer and HEAD_DEPTH + 1 once it does not.
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [SHORT_LEN_W-1:0]     short_len;
    num_phase_t                 phase;
    logic                       ident_ok;
    logic                       overflow;
  } lex_state_t;

  // Keywords packed with the first character in the top byte, zero padded.
  localparam logic [8*HEAD_DEPTH-1:0] KW_WORDS [KEYWORD_COUNT] = '{
    {"int", 40'd0}, {"char", 32'd0}, {"float", 24'd0}, {"double", 16'd0},
    {"long", 32'd0}, {"short", 24'd0}, {"while", 24'd0}, {"for", 40'd0},
    {"do", 48'd0}, {"if", 48'd0}, {"else", 32'd0}, {"void", 32'd0},
    {"static", 16'd0}, {"break", 24'd0}, {"continue"}, {"default", 8'd0},
    {"const", 24'd0}, {"switch", 16'd0}, {"case", 32'd0}, {"sizeof", 16'd0},
    {"struct", 16'd0}, {"signed", 16'd0}, {"unsigned"}, {"return", 16'd0}
  };

  localparam logic [SHORT_LEN_W-1:0] KW_LENS [KEYWORD_COUNT] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd5, 4'd3,
    4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd5, 4'd8, 4'd7,
    4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd6, 4'd8, 4'd6
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

endpackage

[rtl/lcc_classify.sv]
module lcc_classify
  import lcc_pkg::*;
(
  input  lex_state_t lex,
  output category_t  category
);

  logic [8*HEAD_DEPTH-1:0] head_word;
  logic                    kw_hit;
  logic                    empty;
  logic                    single_op;
  logic                    double_op;
  logic [7:0]              c0;
  logic [7:0]              c1;

  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_word[8*(HEAD_DEPTH-i)-1 -: 8] = lex.head[i];
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if ((lex.short_len == KW_LENS[k]) && (head_word == KW_WORDS[k])) begin
        kw_hit = 1'b1;
      end
    end
  end

  assign c0    = lex.head[0];
  assign c1    = lex.head[1];
  assign empty = (lex.short_len == '0);

  assign single_op = (c0 == "+") || (c0 == "-") || (c0 == "*") || (c0 == "/") ||
                     (c0 == "%") || (c0 == "=") || (c0 == "<") || (c0 == ">") ||
                     (c0 == "!") || (c0 == "&") || (c0 == "|") || (c0 == "~") ||
                     (c0 == "^");

  assign double_op = ((c0 == "+") && (c1 == "+")) || ((c0 == "-") && (c1 == "-")) ||
                     ((c0 == "=") && (c1 == "=")) || ((c0 == "!") && (c1 == "=")) ||
                     ((c0 == "|") && (c1 == "|")) || ((c0 == "&") && (c1 == "&")) ||
                     ((c0 == ">") && (c1 == "=")) || ((c0 == "<") && (c1 == "="));

  always_comb begin
    if (empty) begin
      category = CAT_UNKNOWN;
    end else if ((c0 == ";") || (c0 == ",") || (c0 == APOSTROPHE)) begin
      category = CAT_SEP;
    end else if ((c0 == "(") || (c0 == ")") || (c0 == "{") || (c0 == "}")) begin
      category = CAT_PAR;
    end else if (!lex.overflow && (lex.short_len == SHORT_LEN_W'(1)) && single_op) begin
      category = CAT_OP;
    end else if (!lex.overflow && (lex.short_len == SHORT_LEN_W'(2)) && double_op) begin
      category = CAT_OP;
    end else if ((lex.phase == NUM_INT) || (lex.phase == NUM_FRAC)) begin
      category = CAT_NUM;
    end else if (!lex.overflow && kw_hit) begin
      category = CAT_KW;
    end else if (lex.ident_ok) begin
      category = CAT_ID;
    end else begin
      category = CAT_UNKNOWN;
    end
  end

endmodule

[rtl/lexeme_category_classifier.sv]
// Output: the result word is registered and shows on out_valid in the cycle after the accepted space.
// Throughput: one character word per cycle; every input word stalls while a result
// word is waiting in the output register and out_ready is low.
// Reset: synchronous rst_n clears the open lexeme and empties the output register.
module lexeme_category_classifier
  import lcc_pkg::*;
#(
  parameter int LEXEME_MAX = LEXEME_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_category,
  output logic [OUT_LEN_W-1:0] out_lexeme_length,
  output logic                 out_overlong
);

  localparam int LEN_W = $clog2(LEXEME_MAX + 1);
  localparam int CNT_W = (LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W;

  logic [HEAD_DEPTH-1:0][7:0] head_r;
  logic [HEAD_DEPTH-1:0][7:0] head_nxt;
  logic [CNT_W-1:0]           len_r;
  logic [CNT_W-1:0]           len_nxt;
  num_phase_t                 phase_r;
  num_phase_t                 phase_nxt;
  logic                       ident_r;
  logic                       ident_nxt;
  logic                       ovf_r;
  logic                       ovf_nxt;

  logic                       out_valid_r;
  category_t                  cat_r;
  logic [OUT_LEN_W-1:0]       olen_r;
  logic                       oovl_r;

  logic                       accept;
  logic                       is_space;
  logic                       dig;
  logic                       idc;
  lex_state_t                 lex;
  category_t                  cat;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_space = (in_ch == SPACE_CHAR);
  assign dig      = is_digit(in_ch);
  assign idc      = is_alpha_us(in_ch);

  always_comb begin
    lex.head      = head_r;
    lex.short_len = (len_r > CNT_W'(HEAD_DEPTH)) ? SHORT_LEN_W'(HEAD_DEPTH + 1)
                                                 : SHORT_LEN_W'(len_r);
    lex.phase     = phase_r;
    lex.ident_ok  = ident_r;
    lex.overflow  = ovf_r;
  end

  lcc_classify u_classify (
    .lex      (lex),
    .category (cat)
  );

  always_comb begin
    head_nxt  = head_r;
    len_nxt   = len_r;
    phase_nxt = phase_r;
    ident_nxt = ident_r;
    ovf_nxt   = ovf_r;
    if (is_space) begin
      head_nxt  = '0;
      len_nxt   = '0;
      phase_nxt = NUM_START;
      ident_nxt = 1'b1;
      ovf_nxt   = 1'b0;
    end else begin
      if (len_r < CNT_W'(HEAD_DEPTH)) begin
        head_nxt[len_r[HEAD_IDX_W-1:0]] = in_ch;
      end
      if (len_r == '0) begin
        phase_nxt = dig ? NUM_INT : ((in_ch == ".") ? NUM_DOT : NUM_START);
        ident_nxt = idc;
      end else begin
        case (phase_r)
          NUM_INT:  phase_nxt = dig ? NUM_INT : ((in_ch == ".") ? NUM_DOT : NUM_START);
          NUM_DOT:  phase_nxt = dig ? NUM_FRAC : NUM_START;
          NUM_FRAC: phase_nxt = dig ? NUM_FRAC : NUM_START;
          default:  phase_nxt = NUM_START;
        endcase
        if (!(idc || dig)) begin
          ident_nxt = 1'b0;
        end
      end
      if (len_r < CNT_W'(LEXEME_MAX)) begin
        len_nxt = len_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      len_r       <= '0;
      phase_r     <= NUM_START;
      ident_r     <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        len_r   <= len_nxt;
        phase_r <= phase_nxt;
        ident_r <= ident_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (accept && is_space) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_space) begin
      cat_r  <= cat;
      olen_r <= len_r[OUT_LEN_W-1:0];
      oovl_r <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_category      = cat_r;
  assign out_lexeme_length = olen_r;
  assign out_overlong      = oovl_r;

endmodule
